// ===== rtl/core/lps_pkg.sv =====
// Shared types, constants and command table for the line position steering block.
`timescale 1ns / 1ps

package lps_pkg;

  // Field widths fixed by the interface
  localparam int PIXEL_W  = 8;
  localparam int ROW_W    = 11;
  localparam int MARGIN_W = 10;
  localparam int DRIVE_W  = 9;
  localparam int TIME_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK_LEVEL    = 2'd0,
    REG_ROW_WIDTH     = 2'd1,
    REG_WIDE_MARGIN   = 2'd2,
    REG_NARROW_MARGIN = 2'd3
  } cfg_reg_t;

  // Configuration reset values
  localparam logic [PIXEL_W-1:0]  DARK_LEVEL_RST    = 8'd65;
  localparam logic [ROW_W-1:0]    ROW_WIDTH_RST     = 11'd640;
  localparam logic [MARGIN_W-1:0] WIDE_MARGIN_RST   = 10'd80;
  localparam logic [MARGIN_W-1:0] NARROW_MARGIN_RST = 10'd40;

  // Steering rules, in priority order
  localparam int NUM_RULES = 5;
  localparam int RULE_W    = 3;

  typedef enum logic [RULE_W-1:0] {
    RULE_STRAIGHT   = 3'd0,
    RULE_SOFT_LEFT  = 3'd1,
    RULE_SOFT_RIGHT = 3'd2,
    RULE_TURN_RIGHT = 3'd3,
    RULE_TURN_LEFT  = 3'd4
  } rule_t;

  // Motor speeds
  localparam logic signed [DRIVE_W-1:0] LEFT_FULL   = -9'sd150;
  localparam logic signed [DRIVE_W-1:0] RIGHT_FULL  = -9'sd140;
  localparam logic signed [DRIVE_W-1:0] DRIVE_SOFT  = -9'sd75;
  localparam logic signed [DRIVE_W-1:0] DRIVE_STOP  = 9'sd0;
  localparam logic [TIME_W-1:0]         MOVE_TIME   = 8'd25;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
  } drive_t;

  // Motor command for each rule
  function automatic drive_t rule_drive(input rule_t r);
    drive_t d;
    case (r)
      RULE_STRAIGHT:   begin d.left = LEFT_FULL;  d.right = RIGHT_FULL; end
      RULE_SOFT_LEFT:  begin d.left = DRIVE_SOFT; d.right = RIGHT_FULL; end
      RULE_SOFT_RIGHT: begin d.left = LEFT_FULL;  d.right = DRIVE_SOFT; end
      RULE_TURN_RIGHT: begin d.left = DRIVE_STOP; d.right = RIGHT_FULL; end
      RULE_TURN_LEFT:  begin d.left = LEFT_FULL;  d.right = DRIVE_STOP; end
      default:         begin d.left = DRIVE_STOP; d.right = DRIVE_STOP; end
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/lps_tracker.sv =====
// Pixel tracker: column counter, first/last dark column, row summary register.
`timescale 1ns / 1ps

module lps_tracker #(
  parameter int MAX_COLUMNS = 1024,
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1),
  localparam int POS_W = $clog2(MAX_COLUMNS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lps_pkg::PIXEL_W-1:0]  dark_level,
  input  logic [lps_pkg::ROW_W-1:0]    row_width,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lps_pkg::PIXEL_W-1:0]  in_gray_pixel,
  input  logic                         in_row_end,
  output logic                         sum_valid,
  input  logic                         sum_ready,
  output logic [POS_W-1:0]             sum_first,
  output logic [POS_W-1:0]             sum_last
);
  import lps_pkg::*;

  localparam int CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] first_r, first_nxt, last_r, last_nxt;
  logic             seen_r, seen_nxt;
  logic             sum_valid_r, sum_valid_nxt;
  logic [POS_W-1:0] sum_first_r, sum_last_r;

  logic             accept, in_range, hit, seen_upd;
  logic [POS_W-1:0] pos, first_upd, last_upd;

  // Only a row-end pixel needs the summary slot free (or draining)
  assign in_ready = !in_row_end || !sum_valid_r || sum_ready;
  assign accept   = in_valid && in_ready;

  // Dark pixel inside the usable part of the row
  assign in_range  = (CMP_W'(col_r) < CMP_W'(row_width)) && (col_r < CNT_W'(MAX_COLUMNS));
  assign hit       = in_range && (in_gray_pixel <= dark_level);
  assign pos       = col_r[POS_W-1:0];
  assign first_upd = (hit && !seen_r) ? pos : first_r;
  assign last_upd  = hit ? pos : last_r;
  assign seen_upd  = seen_r || hit;

  // Row state update; cleared at row end
  always_comb begin
    col_nxt   = col_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (in_row_end) begin
        col_nxt   = '0;
        first_nxt = '0;
        last_nxt  = '0;
        seen_nxt  = 1'b0;
      end else begin
        if (col_r < CNT_W'(MAX_COLUMNS)) begin
          col_nxt = col_r + CNT_W'(1);
        end
        first_nxt = first_upd;
        last_nxt  = last_upd;
        seen_nxt  = seen_upd;
      end
    end
  end

  // Summary handoff: only rows with a dark pixel produce one
  always_comb begin
    sum_valid_nxt = sum_valid_r;
    if (accept && in_row_end && seen_upd) begin
      sum_valid_nxt = 1'b1;
    end else if (sum_ready) begin
      sum_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_r     <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      sum_valid_r <= sum_valid_nxt;
    end
  end

  // Summary payload
  always_ff @(posedge clk) begin
    if (accept && in_row_end) begin
      sum_first_r <= first_upd;
      sum_last_r  <= last_upd;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum_first = sum_first_r;
  assign sum_last  = sum_last_r;

endmodule

// ===== rtl/core/lps_rules.sv =====
// Steering rules: offsets from the middle, rule selection, result register.
`timescale 1ns / 1ps

module lps_rules #(
  parameter int MAX_COLUMNS = 1024,
  localparam int POS_W = $clog2(MAX_COLUMNS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lps_pkg::ROW_W-1:0]           row_width,
  input  logic [lps_pkg::MARGIN_W-1:0]        wide_margin,
  input  logic [lps_pkg::MARGIN_W-1:0]        narrow_margin,
  input  logic                                sum_valid,
  output logic                                sum_ready,
  input  logic [POS_W-1:0]                    sum_first,
  input  logic [POS_W-1:0]                    sum_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lps_pkg::DRIVE_W-1:0]  out_left_drive,
  output logic signed [lps_pkg::DRIVE_W-1:0]  out_right_drive,
  output logic [lps_pkg::TIME_W-1:0]          out_move_time,
  output logic                                out_final_command
);
  import lps_pkg::*;

  // Signed width that holds any offset and margin
  localparam int DW = ((POS_W > MARGIN_W) ? POS_W : MARGIN_W) + 2;
  localparam logic signed [DW-1:0] ZERO_S = '0;

  logic signed [DW-1:0] mid_s, first_s, last_s, left_s, right_s, wide_s, narrow_s;
  logic [NUM_RULES-1:0] hits;
  rule_t                rule_a, rule_b, rule_sel;
  logic                 found_a, found_b;
  logic                 load_ok, load, last_cmd;
  drive_t               drv;

  logic                      phase_r, phase_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] left_r, right_r;
  logic                      final_r;

  // Offsets of the dark span from the middle column
  assign mid_s    = $signed({{(DW - ROW_W + 1){1'b0}}, row_width[ROW_W-1:1]});
  assign first_s  = $signed({{(DW - POS_W){1'b0}}, sum_first});
  assign last_s   = $signed({{(DW - POS_W){1'b0}}, sum_last});
  assign wide_s   = $signed({{(DW - MARGIN_W){1'b0}}, wide_margin});
  assign narrow_s = $signed({{(DW - MARGIN_W){1'b0}}, narrow_margin});
  assign left_s   = mid_s - first_s;
  assign right_s  = last_s - mid_s;

  // Rule tests, all strict and signed
  assign hits[RULE_STRAIGHT]   = (left_s > wide_s) && (right_s > wide_s);
  assign hits[RULE_SOFT_LEFT]  = (left_s > narrow_s) && (left_s < wide_s);
  assign hits[RULE_SOFT_RIGHT] = (right_s > narrow_s) && (right_s < wide_s);
  assign hits[RULE_TURN_RIGHT] = (left_s < narrow_s) && (right_s > ZERO_S);
  assign hits[RULE_TURN_LEFT]  = (left_s > ZERO_S) && (right_s < narrow_s);

  // First two rules that hold, in priority order
  always_comb begin
    rule_a  = RULE_STRAIGHT;
    rule_b  = RULE_STRAIGHT;
    found_a = 1'b0;
    found_b = 1'b0;
    for (int i = 0; i < NUM_RULES; i++) begin
      if (hits[i]) begin
        if (!found_a) begin
          rule_a  = rule_t'(RULE_W'(i));
          found_a = 1'b1;
        end else if (!found_b) begin
          rule_b  = rule_t'(RULE_W'(i));
          found_b = 1'b1;
        end
      end
    end
  end

  // Command sequencing: phase 0 sends the first hit, phase 1 the second
  assign load_ok  = !out_valid_r || out_ready;
  assign rule_sel = phase_r ? rule_b : rule_a;
  assign last_cmd = phase_r || !found_b;
  assign load     = sum_valid && found_a && load_ok;
  assign drv      = rule_drive(rule_sel);

  always_comb begin
    sum_ready = 1'b0;
    phase_nxt = phase_r;
    if (sum_valid && !found_a) begin
      sum_ready = 1'b1;
      phase_nxt = 1'b0;
    end else if (load) begin
      sum_ready = last_cmd;
      phase_nxt = !last_cmd;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= drv.left;
      right_r <= drv.right;
      final_r <= last_cmd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_drive    = left_r;
  assign out_right_drive   = right_r;
  assign out_move_time     = MOVE_TIME;
  assign out_final_command = final_r;

endmodule

// ===== rtl/core/line_position_steering.sv =====
// Top level of the line position steering block.
`timescale 1ns / 1ps

// Line position steering.
// Input channel (in_valid/in_ready): one gray pixel per item, in scan order;
// in_row_end marks the last pixel of a row. Pixels at or below dark_level are
// line; columns at or beyond row_width (or MAX_COLUMNS) are ignored.
// Result channel (out_valid/out_ready): zero to two motor commands per row,
// produced after the row-end pixel; out_final_command marks the last one.
// A row without a dark pixel yields nothing.
// Config port: cfg_we writes cfg_wdata into register cfg_index at the clock
// edge; write it only while the block is idle.
// Path: the row-end pixel goes into the row summary register, then into the
// result register, where out_valid rises; a held result delays that load.
// Throughput: one pixel per cycle; the per-pixel tracker is a compare and a
// counter update. Only a row-end pixel can wait, while the row summary is
// held; with two commands it is held until the second one is loaded.
// Reset: synchronous, active low; clears row state, pending results and sets
// the registers to dark_level 65, row_width 640, wide 80, narrow 40.
// Stall: a held result keeps its payload; pixels keep flowing, only a row-end
// pixel waits while the row summary register is still full.
module line_position_steering #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lps_pkg::PIXEL_W-1:0]         in_gray_pixel,
  input  logic                                in_row_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lps_pkg::DRIVE_W-1:0]  out_left_drive,
  output logic signed [lps_pkg::DRIVE_W-1:0]  out_right_drive,
  output logic [lps_pkg::TIME_W-1:0]          out_move_time,
  output logic                                out_final_command
);
  import lps_pkg::*;

  localparam int POS_W = $clog2(MAX_COLUMNS);

  logic [PIXEL_W-1:0]  dark_level_r;
  logic [ROW_W-1:0]    row_width_r;
  logic [MARGIN_W-1:0] wide_margin_r, narrow_margin_r;

  logic             sum_valid, sum_ready;
  logic [POS_W-1:0] sum_first, sum_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_level_r    <= DARK_LEVEL_RST;
      row_width_r     <= ROW_WIDTH_RST;
      wide_margin_r   <= WIDE_MARGIN_RST;
      narrow_margin_r <= NARROW_MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DARK_LEVEL:    dark_level_r    <= cfg_wdata[PIXEL_W-1:0];
        REG_ROW_WIDTH:     row_width_r     <= cfg_wdata[ROW_W-1:0];
        REG_WIDE_MARGIN:   wide_margin_r   <= cfg_wdata[MARGIN_W-1:0];
        REG_NARROW_MARGIN: narrow_margin_r <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  lps_tracker #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .dark_level    (dark_level_r),
    .row_width     (row_width_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_gray_pixel (in_gray_pixel),
    .in_row_end    (in_row_end),
    .sum_valid     (sum_valid),
    .sum_ready     (sum_ready),
    .sum_first     (sum_first),
    .sum_last      (sum_last)
  );

  lps_rules #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_rules (
    .clk               (clk),
    .rst_n             (rst_n),
    .row_width         (row_width_r),
    .wide_margin       (wide_margin_r),
    .narrow_margin     (narrow_margin_r),
    .sum_valid         (sum_valid),
    .sum_ready         (sum_ready),
    .sum_first         (sum_first),
    .sum_last          (sum_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_move_time     (out_move_time),
    .out_final_command (out_final_command)
  );

endmodule

// ===== rtl/core/lps_checker.sv =====
// Port-level checks for the line position steering block, bound to the top level.
`timescale 1ns / 1ps

module lps_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lps_pkg::DRIVE_W-1:0]  out_left_drive,
  input logic signed [lps_pkg::DRIVE_W-1:0]  out_right_drive,
  input logic [lps_pkg::TIME_W-1:0]          out_move_time,
  input logic                                out_final_command
);
  import lps_pkg::*;

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_drive)
      && $stable(out_right_drive) && $stable(out_final_command))
    else $error("result changed while stalled");

  // A non-final command is followed at once by the second command of the row
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_command |=> out_valid)
    else $error("second command of row missing");

  // No rule stops both motors, and duration is constant
  a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_move_time == MOVE_TIME)
      && !(out_left_drive == DRIVE_STOP && out_right_drive == DRIVE_STOP))
    else $error("malformed command");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_position_steering lps_checker u_lps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_left_drive    (out_left_drive),
  .out_right_drive   (out_right_drive),
  .out_move_time     (out_move_time),
  .out_final_command (out_final_command)
);
